// File: design/uri_percent_decoder_defines.svh
// Assertion macros shared by the percent decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef URI_PERCENT_DECODER_DEFINES_SVH
`define URI_PERCENT_DECODER_DEFINES_SVH

// cond must be followed by conseq in the same cycle
`define UPD_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("implication check failed");

// cond must never hold
`define UPD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: design/upd_pkg.sv
// Types, character constants and hex helper for the percent decoder.
// No dependencies; imported by every module of the block.
package upd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_URI_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REDIRECT_MODE = 2'd1;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_QMARK   = 8'h3f;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'h7f;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stopped;
   } rsp_type;

   typedef struct packed {
      logic uri_mode;
      logic redirect_mode;
   } cfg_type;

   // One queued run of one to three output bytes
   typedef struct packed {
      logic [1:0] count;
      logic       stop;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } run_type;

   typedef struct packed {
      logic       valid;
      logic       letter;
      logic [3:0] nib;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] ch);
      hex_type    h;
      logic [7:0] lower;
      lower    = ch | CH_SPACE;
      h.valid  = 1'b0;
      h.letter = 1'b0;
      h.nib    = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         h.valid = 1'b1;
         h.nib   = ch[3:0];
      end else if (lower >= 8'h61 && lower <= 8'h66) begin
         h.valid  = 1'b1;
         h.letter = 1'b1;
         h.nib    = lower[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

// File: design/upd_front.sv
// Front end: accepts raw bytes, tracks escape state and builds output runs.
// Depends on upd_pkg.
module upd_front (
   input  logic             clock,
   input  logic             reset,
   input  upd_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  upd_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output upd_pkg::run_type q_run
);
   import upd_pkg::*;

   localparam logic [1:0] PHASE_PLAIN  = 2'd0;
   localparam logic [1:0] PHASE_PCT    = 2'd1;
   localparam logic [1:0] PHASE_DIGIT1 = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] hi_ff, hi_in;
   logic [7:0] first_ff, first_in;
   logic       halted_ff, halted_in;

   hex_type    hv;
   logic [7:0] ch;
   logic [7:0] dec;
   logic       printable;
   logic       reesc;
   logic       emit;
   logic       accept;
   run_type    run;

   assign ch        = req_data.in_byte;
   assign hv        = hex_decode(ch);
   assign dec       = {hi_ff, hv.nib};
   assign printable = (dec > CH_PERCENT) && (dec < CH_DEL);
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in  = phase_ff;
      hi_in     = hi_ff;
      first_in  = first_ff;
      halted_in = halted_ff;
      emit      = 1'b0;
      reesc     = 1'b0;
      run       = '{count: 2'd1, stop: 1'b0, b0: ch, b1: first_ff, b2: ch};
      if (!halted_ff) begin
         unique case (phase_ff)
            PHASE_PCT: begin
               if (hv.valid) begin
                  hi_in    = hv.nib;
                  first_in = ch;
                  phase_in = PHASE_DIGIT1;
               end else begin
                  phase_in = PHASE_PLAIN;
                  emit     = 1'b1;
               end
            end
            PHASE_DIGIT1: begin
               phase_in = PHASE_PLAIN;
               if (hv.valid) begin
                  emit = 1'b1;
                  priority if (!hv.letter) begin
                     reesc = cfg.redirect_mode && !printable;
                  end else if (cfg.uri_mode) begin
                     halted_in = (dec == CH_QMARK);
                  end else if (cfg.redirect_mode) begin
                     halted_in = (dec == CH_QMARK);
                     reesc     = (dec != CH_QMARK) && !printable;
                  end else begin
                     reesc = 1'b0;
                  end
                  if (reesc) begin
                     run.count = 2'd3;
                     run.b0    = CH_PERCENT;
                  end else begin
                     run.b0   = dec;
                     run.stop = halted_in;
                  end
               end
            end
            default: begin
               priority if (ch == CH_QMARK && (cfg.uri_mode || cfg.redirect_mode)) begin
                  halted_in = 1'b1;
                  emit      = 1'b1;
                  run.stop  = 1'b1;
               end else if (ch == CH_PERCENT) begin
                  phase_in = PHASE_PCT;
               end else if (ch == CH_PLUS) begin
                  emit   = 1'b1;
                  run.b0 = CH_SPACE;
               end else begin
                  phase_in = PHASE_PLAIN;
                  emit     = 1'b1;
               end
            end
         endcase
      end
      // end of string clears all escape state
      if (req_data.end_of_string) begin
         phase_in  = PHASE_PLAIN;
         hi_in     = 4'd0;
         first_in  = 8'd0;
         halted_in = 1'b0;
      end
   end

   assign q_push = accept && emit;
   assign q_run  = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_PLAIN;
         hi_ff     <= 4'd0;
         first_ff  <= 8'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hi_ff     <= hi_in;
         first_ff  <= first_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// File: design/upd_queue.sv
// Short run queue between the front end and the output stage.
// Depends on upd_pkg and the assertion macro header.
`include "uri_percent_decoder_defines.svh"
module upd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  upd_pkg::run_type       push_run,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output upd_pkg::run_type       head
);
   import upd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   run_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UPD_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `UPD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)
   `UPD_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

// File: design/upd_back.sv
// Output stage: drains queued runs into rsp_data one byte per cycle unless stalled.
// Depends on upd_pkg and the assertion macro header.
`include "uri_percent_decoder_defines.svh"
module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  upd_pkg::run_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output upd_pkg::rsp_type rsp_data
);
   import upd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       advance;
   logic       last;
   logic [7:0] sel;

   assign advance = !valid_ff || rsp_ready;
   assign last    = (idx_ff == q_head.count - 2'd1);

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel = q_head.b0;
         2'd1:    sel = q_head.b1;
         default: sel = q_head.b2;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            data_in = '{out_byte: sel, run_last: last, stopped: q_head.stop};
            // drop the run once its final byte is out
            q_pop   = last;
            idx_in  = last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `UPD_ASSERT_IMPLY(a_stop_is_last, clock, reset, valid_ff && data_ff.stopped, data_ff.run_last)
   `UPD_ASSERT_IMPLY(a_mid_run_held, clock, reset, idx_ff != 2'd0, !q_empty)
   `UPD_ASSERT_IMPLY(a_idx_in_run, clock, reset, !q_empty, idx_ff < q_head.count)

endmodule

// File: design/uri_percent_decoder.sv
// URI percent decoder, one raw byte in per item, zero to three bytes out.
//
// req channel: req_data carries in_byte and end_of_string; an item is taken
// when req_valid and req_ready are both high. rsp channel: rsp_data carries
// out_byte, run_last (last byte caused by that input) and stopped (the '?'
// that halts decoding). csr channel: csr_index 0 writes uri_mode, 1 writes
// redirect_mode from bit 0 of csr_data; other indexes are ignored. csr_ready
// is always high; write only while the block is idle.
// Path: a byte's first output reaches rsp_data through the run queue and
// then the output register. Throughput: one input byte per cycle while the
// queue is not full and each gives at most one output byte; the output
// register drains one byte per cycle while rsp_ready allows, so a three-byte
// re-escape occupies the output byte by byte and the run queue (QUEUE_DEPTH runs) absorbs
// it until it fills. If the receiver stalls, the output holds, the queue fills
// and req_ready drops once QUEUE_DEPTH runs are waiting; inputs that emit
// nothing still need a free queue slot to be taken.
// Reset: synchronous, clears the escape state, the queue and rsp_valid;
// uri_mode returns to 1 and redirect_mode to 0.
module uri_percent_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  upd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output upd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [upd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [upd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import upd_pkg::*;

   logic    uri_mode_ff;
   logic    redirect_mode_ff;
   cfg_type cfg;
   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   run_type q_run;
   run_type q_head;

   assign csr_ready = 1'b1;
   assign cfg       = '{uri_mode: uri_mode_ff, redirect_mode: redirect_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         uri_mode_ff      <= 1'b1;
         redirect_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_URI_MODE) begin
            uri_mode_ff <= csr_data[0];
         end
         if (csr_index == CSR_REDIRECT_MODE) begin
            redirect_mode_ff <= csr_data[0];
         end
      end
   end

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_run     (q_run)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_run (q_run),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
